// ===== rtl/unique_row_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// unique_row_filter_unit_defines
// assertion macros shared by the unique row filter modules
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ROW_FILTER_UNIT_DEFINES_SVH
`define UNIQUE_ROW_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define URF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("unique row filter check failed");

// next-cycle implication, checked outside reset
`define URF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("unique row filter check failed");

`endif

// ===== rtl/urf_pkg.sv =====
// ----------------------------------------------------------------------------
// urf_pkg
// shared sizes, types and helpers of the unique row filter
// ----------------------------------------------------------------------------
package urf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ROW_BITS    = 64;
  localparam int WIDTH_W     = 7;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(64);

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic                last;
  } urf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } urf_qstat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_EMIT
  } urf_state_t;

  // mask of the low bits that take part, width clamped to [1, ROW_BITS]
  function automatic logic [ROW_BITS-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0]  weff;
    logic [ROW_BITS-1:0] m;
    weff = w;
    if (w == '0) begin
      weff = WIDTH_W'(1);
    end
    if (w > WIDTH_W'(ROW_BITS)) begin
      weff = WIDTH_W'(ROW_BITS);
    end
    for (int j = 0; j < ROW_BITS; j++) begin
      m[j] = (WIDTH_W'(j) < weff);
    end
    return m;
  endfunction

endpackage

// ===== rtl/unique_row_filter_unit.sv =====
// ----------------------------------------------------------------------------
// unique_row_filter_unit
// passes each row of a boolean matrix with a first-occurrence flag
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall move one row (row_bits, last_row) per
//   transfer; only the low row_width bits take part and are passed on
// output channel: out_valid / out_stall move one result per input row:
//   kept_row (masked row), is_first, table_full, matrix_end
// row_width is written with row_width_we; the user writes it only while no row is in flight (not enforced)
// path of a new row: the front register and the queue, then a read/compare pair
//   for each of the n rows stored so far in the current matrix (a match
//   ends the scan early and shortens it), then the result register
// one row is searched at a time; the search engine reads the seen
//   table through its single port, one entry per read/compare pair
// a two-entry queue lets the input side take rows while a search runs
// the output register holds a result under stall; new searches still start
//   but wait to deliver until the register frees up
// the row flagged last_row empties the table once its result is produced
// reset: synchronous rst empties the table and pipeline, row_width -> 64
// ----------------------------------------------------------------------------
module unique_row_filter_unit
  import urf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                row_width_we,
  input  logic [WIDTH_W-1:0]  row_width,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ROW_BITS-1:0] row_bits,
  input  logic                last_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ROW_BITS-1:0] kept_row,
  output logic                is_first,
  output logic                table_full,
  output logic                matrix_end
);

  // active width register
  logic [WIDTH_W-1:0] width_reg;

  // front to queue, queue to back
  logic       push;
  urf_item_t  push_item;
  logic       pop;
  urf_item_t  head;
  urf_qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= ROW_WIDTH_RESET;
    end else if (row_width_we) begin
      width_reg <= row_width;
    end
  end

  // masks rows as they arrive
  urf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_bits  (row_bits),
    .last_row  (last_row),
    .row_width (width_reg),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // decouples intake from the table search
  urf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // table search, store and result register
  urf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kept_row   (kept_row),
    .is_first   (is_first),
    .table_full (table_full),
    .matrix_end (matrix_end)
  );

endmodule

// ===== rtl/urf_front.sv =====
// ----------------------------------------------------------------------------
// urf_front
// input stage: takes rows, masks them to the active width, feeds the queue
// ----------------------------------------------------------------------------
module urf_front
  import urf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ROW_BITS-1:0] row_bits,
  input  logic                last_row,
  input  logic [WIDTH_W-1:0]  row_width,
  input  urf_qstat_t          qstat,
  output logic                push,
  output urf_item_t           push_item
);

  logic      fr_valid;
  urf_item_t fr_item;
  logic      accept;

  assign push     = fr_valid && !qstat.full;
  assign in_stall = fr_valid && qstat.full;
  assign accept   = in_valid && !in_stall;
  assign push_item = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item.row  <= row_bits & width_mask(row_width);
      fr_item.last <= last_row;
    end
  end

endmodule

// ===== rtl/urf_queue.sv =====
// ----------------------------------------------------------------------------
// urf_queue
// short queue between the input stage and the search engine
// ----------------------------------------------------------------------------
`include "unique_row_filter_unit_defines.svh"

module urf_queue
  import urf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  urf_item_t  push_item,
  input  logic       pop,
  output urf_item_t  head,
  output urf_qstat_t qstat
);

  urf_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign qstat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign head        = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `URF_ASSERT_NOW(a_no_push_full, clk, rst, push, !qstat.full)
  `URF_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !qstat.empty)
  `URF_ASSERT_NEXT(a_fill_up, clk, rst, push && !pop, fill == $past(fill) + QCNT_W'(1))

endmodule

// ===== rtl/urf_back.sv =====
// ----------------------------------------------------------------------------
// urf_back
// search engine: scans the seen table, stores new rows, drives the result
// ----------------------------------------------------------------------------
`include "unique_row_filter_unit_defines.svh"

module urf_back
  import urf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  urf_item_t           head,
  input  urf_qstat_t          qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ROW_BITS-1:0] kept_row,
  output logic                is_first,
  output logic                table_full,
  output logic                matrix_end
);

  urf_state_t          state;
  urf_state_t          state_next;
  logic [ROW_BITS-1:0] seen_rows [TABLE_DEPTH];
  logic [ROW_BITS-1:0] rd_data;
  logic [ROW_BITS-1:0] cur_row;
  logic                cur_last;
  logic                found;
  logic [IDX_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    seen_count;
  logic                emit;
  logic                rd_en;
  logic                hit;
  logic                scan_end;
  logic                has_room;

  assign hit      = (rd_data == cur_row);
  assign scan_end = (CNT_W'(scan_idx) + CNT_W'(1) == seen_count);
  assign has_room = (seen_count < CNT_W'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!qstat.empty) begin
          state_next = (seen_count == '0) ? S_EMIT : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (hit || scan_end) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_READ;
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop   = 1'b0;
    rd_en = 1'b0;
    emit  = 1'b0;
    case (state)
      S_IDLE:  pop   = !qstat.empty;
      S_READ:  rd_en = 1'b1;
      S_CMP:   ;
      S_EMIT:  emit  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= seen_rows[scan_idx];
    end
    if (emit && !found && has_room) begin
      seen_rows[seen_count[IDX_W-1:0]] <= cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_row  <= head.row;
      cur_last <= head.last;
      found    <= 1'b0;
      scan_idx <= '0;
    end else if (state == S_CMP) begin
      if (hit) begin
        found <= 1'b1;
      end else begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        if (cur_last) begin
          seen_count <= '0;
        end else if (!found && has_room) begin
          seen_count <= seen_count + CNT_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kept_row   <= cur_row;
      is_first   <= !found;
      table_full <= !found && !has_room;
      matrix_end <= cur_last;
    end
  end

  `URF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, seen_count <= CNT_W'(TABLE_DEPTH))
  `URF_ASSERT_NOW(a_scan_in_table, clk, rst, state == S_READ, CNT_W'(scan_idx) < seen_count)
  `URF_ASSERT_NEXT(a_clear_on_last, clk, rst, emit && cur_last, seen_count == '0)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for unique_row_filter_unit: rows are streamed through
// the valid/stall input channel, every accepted row is run through a local
// model of the seen table, and each result transfer is checked field by field
// against the oldest predicted result; covers width clamping, duplicates,
// table overflow, width changes inside a matrix and random back-pressure
// ----------------------------------------------------------------------------
module tb_top
  import urf_pkg::*;
();

  // no accepted transfer on either channel for this many cycles ends the run;
  // the slowest row (full table search) plus the long receiver hold-off and
  // the longest gaps stays well under the limit
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ROW_TARGET     = 1450;
  localparam int HOLD_AT_RESULT = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic [ROW_BITS-1:0] bits;
    logic                last;
  } row_item_t;

  typedef struct {
    logic [ROW_BITS-1:0] kept;
    logic                first;
    logic                full;
    logic                mend;
  } row_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // block ports, all at known values from time zero
  logic                row_width_we = 1'b0;
  logic [WIDTH_W-1:0]  row_width    = ROW_WIDTH_RESET;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [ROW_BITS-1:0] row_bits     = '0;
  logic                last_row     = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [ROW_BITS-1:0] kept_row;
  logic                is_first;
  logic                table_full;
  logic                matrix_end;

  unique_row_filter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .row_width_we (row_width_we),
    .row_width    (row_width),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row_bits     (row_bits),
    .last_row     (last_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kept_row     (kept_row),
    .is_first     (is_first),
    .table_full   (table_full),
    .matrix_end   (matrix_end)
  );

  // rows waiting to be offered, and results waiting to come out
  row_item_t   pending_rows[$];
  row_result_t expected_results[$];

  int queued_count   = 0;  // rows handed to the driver
  int accepted_count = 0;  // rows taken by the block
  int results_seen   = 0;
  int firsts_seen    = 0;
  int overflows_seen = 0;
  int matrices_seen  = 0;
  int error_count    = 0;
  int hold_left      = 0;  // receiver hold-off, owned by the monitor
  bit hold_done      = 1'b0;
  bit quiet_phase    = 1'b0; // no idling on either side while set

  // local copy of the seen table and the width register
  logic [ROW_BITS-1:0] seen_table[TABLE_DEPTH];
  int                  seen_entries;
  logic [WIDTH_W-1:0]  cur_width;

  // low-bit mask for a width value, clamped to [1, ROW_BITS]
  function automatic logic [ROW_BITS-1:0] compare_mask(input logic [WIDTH_W-1:0] w);
    int eff;
    eff = int'(w);
    if (eff < 1) eff = 1;
    if (eff > ROW_BITS) eff = ROW_BITS;
    if (eff >= 64) return '1;
    return (64'd1 << eff) - 64'd1;
  endfunction

  // search the seen table, store a new row if there is room, clear on last row
  function automatic row_result_t filter_row(input logic [ROW_BITS-1:0] bits,
                                             input logic last);
    row_result_t r;
    logic        found;
    found   = 1'b0;
    r.kept  = bits & compare_mask(cur_width);
    r.full  = 1'b0;
    r.mend  = last;
    for (int i = 0; i < seen_entries; i++) begin
      if (seen_table[i] == r.kept) found = 1'b1;
    end
    if (!found) begin
      if (seen_entries < TABLE_DEPTH) begin
        seen_table[seen_entries] = r.kept;
        seen_entries++;
      end else begin
        r.full = 1'b1;
      end
    end
    r.first = !found;
    if (last) seen_entries = 0;
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // driver: offers pending rows, predicts each accepted transfer
  // --------------------------------------------------------------------------
  int        gap_left = 0;
  row_item_t next_row;

  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      seen_entries = 0;
      cur_width    = ROW_WIDTH_RESET;
      gap_left     = 0;
    end else begin
      // register writes only land while nothing is in flight
      if (row_width_we) cur_width = row_width;
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), filter_row(row_bits, last_row));
        accepted_count++;
      end
      // a stalled payload stays put; otherwise pick what to show next
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          next_row = pending_rows.pop_front();
          in_valid <= 1'b1;
          row_bits <= next_row.bits;
          last_row <= next_row.last;
          gap_left = (quiet_phase || $urandom_range(0, 1) == 0) ? 0 : pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each result transfer and drives the receiver stall
  // --------------------------------------------------------------------------
  int          stall_left = 0;
  row_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, row %h", kept_row));
        end else begin
          want = expected_results.pop_front();
          if (kept_row !== want.kept)
            report_mismatch($sformatf("kept_row %h, want %h", kept_row, want.kept));
          if (is_first !== want.first)
            report_mismatch($sformatf("is_first %b, want %b", is_first, want.first));
          if (table_full !== want.full)
            report_mismatch($sformatf("table_full %b, want %b", table_full, want.full));
          if (matrix_end !== want.mend)
            report_mismatch($sformatf("matrix_end %b, want %b", matrix_end, want.mend));
        end
        results_seen++;
        if (is_first === 1'b1) firsts_seen++;
        if (table_full === 1'b1) overflows_seen++;
        if (matrix_end === 1'b1) matrices_seen++;
        // one long hold-off so the queue fills and the input side backs up;
        // it waits for enough rows still to be offered
        if (results_seen >= HOLD_AT_RESULT && !hold_done && pending_rows.size() >= 8) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = pick_idle();
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: counts cycles with no transfer on either channel
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("unique_row_filter_unit test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_row(input logic [ROW_BITS-1:0] bits, input logic last);
    row_item_t it;
    it.bits = bits;
    it.last = last;
    pending_rows.insert(pending_rows.size(), it);
    queued_count++;
  endtask

  // every queued row taken and every result out: the block is idle
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] w);
    @(posedge clk);
    row_width_we <= 1'b1;
    row_width    <= w;
    @(posedge clk);
    row_width_we <= 1'b0;
  endtask

  // one matrix of rows; small ones lean on repeats, big ones overflow the
  // table and then revisit both stored and unstored rows
  task automatic queue_matrix(input int n, input bit big, input bit ends,
                              input logic [WIDTH_W-1:0] w);
    logic [ROW_BITS-1:0] pool[$];
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] bits;
    int                  pick;
    int                  style;
    mask = compare_mask(w);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pool.size() > 0 && ((big && (i >= 70 || pick < 10)) || (!big && pick < 55))) begin
        // repeat: same compared bits, fresh noise above the width
        bits = pool[$urandom_range(0, pool.size() - 1)];
        bits = bits ^ ({$urandom(), $urandom()} & ~mask);
        if (big && i >= 70 && $urandom_range(0, 1) == 0)
          bits = pool[$urandom_range(TABLE_DEPTH, pool.size() - 1)];
      end else begin
        style = big ? 0 : $urandom_range(0, 4);
        case (style)
          0, 1: begin
            bits = {$urandom(), $urandom()};
          end
          2: begin
            bits = 64'd1 << $urandom_range(0, ROW_BITS - 1);
          end
          3: begin
            bits = ($urandom_range(0, 1) == 0) ? '0 : '1;
          end
          default: begin
            bits = {$urandom(), $urandom()} & 64'h3;
          end
        endcase
      end
      pool.insert(pool.size(), bits);
      push_row(bits, (i == n - 1) && ends);
    end
  endtask

  int                 phase_no;
  int                 nmat;
  int                 r;
  bit                 big_phase;
  logic [WIDTH_W-1:0] w;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset width: extremes, a repeat, the top bit,
    // last row clearing the table
    push_row('0, 1'b0);
    push_row('1, 1'b0);
    push_row('0, 1'b0);
    push_row(64'h8000_0000_0000_0000, 1'b0);
    push_row('1, 1'b1);
    push_row('1, 1'b1);
    wait_drained();

    // width zero behaves as one bit
    write_width('0);
    push_row(64'h2, 1'b0);
    push_row(64'h3, 1'b0);
    push_row(64'hFFFE, 1'b1);
    wait_drained();

    // width above the row size behaves as the full row
    write_width('1);
    push_row('1, 1'b0);
    push_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    push_row('1, 1'b1);
    wait_drained();

    // width changed inside a matrix: stored rows keep their old mask
    write_width(WIDTH_W'(64));
    push_row(64'h1_0000_0005, 1'b0);
    wait_drained();
    write_width(WIDTH_W'(4));
    push_row(64'h5, 1'b0);
    push_row(64'h15, 1'b0);
    wait_drained();
    write_width(WIDTH_W'(64));
    push_row(64'h1_0000_0005, 1'b0);
    push_row(64'h5, 1'b1);
    wait_drained();

    // random phases: a width per phase, a few matrices each; every twelfth
    // phase is one big matrix that runs past the table size
    phase_no = 0;
    while (queued_count < ROW_TARGET) begin
      big_phase = (phase_no % 12 == 1);
      r = $urandom_range(0, 99);
      if (big_phase) begin
        w = (r < 40) ? WIDTH_W'(64) : (r < 60) ? '1 : WIDTH_W'($urandom_range(56, 127));
      end else if (r < 12) begin
        w = '0;
      end else if (r < 22) begin
        w = WIDTH_W'(1);
      end else if (r < 32) begin
        w = WIDTH_W'($urandom_range(2, 8));
      end else if (r < 42) begin
        w = WIDTH_W'(63);
      end else if (r < 55) begin
        w = WIDTH_W'(64);
      end else if (r < 65) begin
        w = WIDTH_W'($urandom_range(65, 127));
      end else begin
        w = WIDTH_W'($urandom_range(1, 64));
      end
      write_width(w);
      quiet_phase = ($urandom_range(0, 3) == 0);
      nmat = big_phase ? 1 : $urandom_range(1, 4);
      for (int m = 0; m < nmat; m++) begin
        // the last matrix of a phase may run on under the next width
        queue_matrix(big_phase ? $urandom_range(66, 90) : $urandom_range(1, 12),
                     big_phase, (m < nmat - 1) || ($urandom_range(0, 9) < 7), w);
      end
      wait_drained();
      phase_no++;
    end

    quiet_phase = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("rows checked: %0d in %0d phases, %0d matrices ended", results_seen,
             phase_no, matrices_seen);
    $display("first occurrences: %0d, rows turned away by a full table: %0d",
             firsts_seen, overflows_seen);
    if (error_count == 0) begin
      $display("unique_row_filter_unit test passed");
    end else begin
      $display("unique_row_filter_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/urf_pkg.sv
rtl/urf_front.sv
rtl/urf_queue.sv
rtl/urf_back.sv
rtl/unique_row_filter_unit.sv
test/tb_top.sv
